>>> hw/rtl/fat_directory_entry_parser_assert.svh
// ----------------------------------------------------------------------------
// FAT directory entry parser - assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FAT_DIRECTORY_ENTRY_PARSER_ASSERT_SVH
`define FAT_DIRECTORY_ENTRY_PARSER_ASSERT_SVH

// Same-cycle implication.
`define FDEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FDEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fdep_pkg.sv
// ----------------------------------------------------------------------------
// fdep_pkg
// Shared constants, types and the long-name offset table of the parser.
// ----------------------------------------------------------------------------
package fdep_pkg;

  localparam int NAME_CHARS_MAX_DEF = 32;

  localparam int          ENTRY_LEN    = 32;
  localparam int          LFN_CHARS    = 13;
  localparam int          ATTR_OFS     = 'h0B;
  localparam int          TIME_OFS     = 'h16;
  localparam int          DATE_OFS     = 'h18;
  localparam int          CLUSTER_OFS  = 'h1A;
  localparam int          SIZE_OFS     = 'h1C;
  localparam logic [7:0]  ATTR_LONG    = 8'h0F;
  localparam logic [7:0]  MARK_END     = 8'h00;
  localparam logic [7:0]  MARK_DELETED = 8'hE5;
  localparam logic [11:0] YEAR_BASE    = 12'd1980;

  typedef logic [7:0] entry_t [ENTRY_LEN];

  typedef struct packed {
    logic [63:0] name;
    logic [23:0] extension;
    logic [7:0]  attribute;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [4:0]  second_field;
    logic [31:0] file_size;
    logic [15:0] first_cluster;
  } rec_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } lfn_slot_t;

  // Byte offset within a long-name entry -> character slot (0..12)
  function automatic lfn_slot_t lfn_slot(input logic [4:0] pos);
    lfn_slot_t s;
    s.hit = 1'b1;
    unique case (pos)
      5'd1:    s.idx = 4'd0;
      5'd3:    s.idx = 4'd1;
      5'd5:    s.idx = 4'd2;
      5'd7:    s.idx = 4'd3;
      5'd9:    s.idx = 4'd4;
      5'd14:   s.idx = 4'd5;
      5'd16:   s.idx = 4'd6;
      5'd18:   s.idx = 4'd7;
      5'd20:   s.idx = 4'd8;
      5'd22:   s.idx = 4'd9;
      5'd24:   s.idx = 4'd10;
      5'd28:   s.idx = 4'd11;
      5'd30:   s.idx = 4'd12;
      default: begin
        s.hit = 1'b0;
        s.idx = 4'd0;
      end
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/fdep_record_decode.sv
// ----------------------------------------------------------------------------
// fdep_record_decode
// Unpacks a 32-byte short-name entry into record fields.
// ----------------------------------------------------------------------------
module fdep_record_decode (
  input  fdep_pkg::entry_t entry,
  output fdep_pkg::rec_t   rec
);

  logic [15:0] date;
  logic [15:0] tim;

  assign date = {entry[fdep_pkg::DATE_OFS + 1], entry[fdep_pkg::DATE_OFS]};
  assign tim  = {entry[fdep_pkg::TIME_OFS + 1], entry[fdep_pkg::TIME_OFS]};

  always_comb begin
    rec.name          = {entry[7], entry[6], entry[5], entry[4],
                         entry[3], entry[2], entry[1], entry[0]};
    rec.extension     = {entry[10], entry[9], entry[8]};
    rec.attribute     = entry[fdep_pkg::ATTR_OFS];
    rec.year          = {5'd0, date[15:9]} + fdep_pkg::YEAR_BASE;
    rec.month         = date[8:5];
    rec.day           = date[4:0];
    rec.hour          = tim[15:11];
    rec.minute        = tim[10:5];
    rec.second_field  = tim[4:0];
    rec.file_size     = {entry[fdep_pkg::SIZE_OFS + 3], entry[fdep_pkg::SIZE_OFS + 2],
                         entry[fdep_pkg::SIZE_OFS + 1], entry[fdep_pkg::SIZE_OFS]};
    rec.first_cluster = {entry[fdep_pkg::CLUSTER_OFS + 1], entry[fdep_pkg::CLUSTER_OFS]};
  end

endmodule

>>> hw/rtl/fat_directory_entry_parser.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_parser
// FAT directory byte stream parser: long-name characters, then entry record.
// ----------------------------------------------------------------------------
// Takes one directory byte per cycle. Long-name characters are written into
// the name store as their bytes arrive (speculatively, at the current fill
// plus their slot); the fill only advances if the entry's attribute turns
// out to be long-name at its last byte, so stray writes past the fill are
// never read. After the last byte of a live short-name entry, input stalls
// while the stored characters and then the record are read out, one per
// cycle unless the output is held off, through the name store's single read
// port, whose registered data is the output register. The record is decoded
// from the held entry bytes. Outside such a read-out the block accepts a
// byte every cycle, also while a result still waits on rec_ready. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
`include "fat_directory_entry_parser_assert.svh"

module fat_directory_entry_parser #(
  parameter int NAME_CHARS_MAX = fdep_pkg::NAME_CHARS_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // directory byte channel
  input  logic        dir_valid,
  output logic        dir_ready,
  input  logic [7:0]  dir_byte,
  input  logic        dir_start,
  // result channel
  output logic        rec_valid,
  input  logic        rec_ready,
  output logic        is_record,
  output logic [63:0] name_or_char,
  output logic [23:0] extension,
  output logic [7:0]  attribute,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [4:0]  second_field,
  output logic [31:0] file_size,
  output logic [15:0] first_cluster
);

  localparam int IDX_W = $clog2(NAME_CHARS_MAX);
  localparam int CNT_W = $clog2(NAME_CHARS_MAX + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int REC_TAIL_W = $bits(fdep_pkg::rec_t) - 64;
  localparam logic [SUM_W-1:0] CHARS_MAX = SUM_W'(NAME_CHARS_MAX);
  localparam logic [SUM_W-1:0] LFN_ADD   = SUM_W'(fdep_pkg::LFN_CHARS);
  localparam logic [4:0]       POS_LAST  = 5'(fdep_pkg::ENTRY_LEN - 1);

  // control state
  logic [4:0]       byte_position;
  logic             dir_ended;
  logic [CNT_W-1:0] name_count;
  logic             drain_active;  // characters / record being read out
  logic [CNT_W-1:0] drain_idx;
  logic [CNT_W-1:0] drain_cnt;

  // payload
  fdep_pkg::entry_t entry_bytes;
  logic [7:0]       name_store [NAME_CHARS_MAX];
  fdep_pkg::rec_t   out_rec;
  logic             out_is_record;
  fdep_pkg::rec_t   dec_rec;

  // per-byte decode
  logic             accept;
  logic             live;
  logic             ended_eff;
  logic [4:0]       pos_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic             end_mark;
  logic             entry_done;
  logic             is_long;
  logic             is_deleted;
  logic             drain_go;
  fdep_pkg::lfn_slot_t slot;
  logic [SUM_W-1:0] wr_addr_full;
  logic             wr_en;
  logic [SUM_W-1:0] lfn_fill;
  logic [CNT_W-1:0] lfn_count_next;
  logic             out_free;
  logic             drain_char;

  assign dir_ready = !drain_active;
  assign accept    = dir_valid && dir_ready;

  // dir_start clears position, end flag and fill before the byte is used
  assign ended_eff = dir_start ? 1'b0 : dir_ended;
  assign pos_eff   = dir_start ? 5'd0 : byte_position;
  assign cnt_eff   = dir_start ? '0 : name_count;
  assign live      = accept && !ended_eff;

  assign end_mark   = live && (pos_eff == 5'd0) && (dir_byte == fdep_pkg::MARK_END);
  assign entry_done = live && (pos_eff == POS_LAST);
  // byte 31 is still in flight; attribute and first byte are already held
  assign is_long    = entry_bytes[fdep_pkg::ATTR_OFS] == fdep_pkg::ATTR_LONG;
  assign is_deleted = entry_bytes[0] == fdep_pkg::MARK_DELETED;
  // live short-name entry finished: read-out follows
  assign drain_go   = entry_done && !is_long && !is_deleted;

  assign slot         = fdep_pkg::lfn_slot(pos_eff);
  assign wr_addr_full = {1'b0, cnt_eff} + SUM_W'(slot.idx);
  assign wr_en        = live && slot.hit && (wr_addr_full < CHARS_MAX);

  assign lfn_fill       = {1'b0, cnt_eff} + LFN_ADD;
  assign lfn_count_next = (lfn_fill < CHARS_MAX) ? lfn_fill[CNT_W-1:0]
                                                 : CHARS_MAX[CNT_W-1:0];

  assign out_free   = !rec_valid || rec_ready;
  assign drain_char = drain_idx < drain_cnt;

  fdep_record_decode u_decode (
    .entry (entry_bytes),
    .rec   (dec_rec)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 5'd0;
      dir_ended     <= 1'b0;
      name_count    <= '0;
      drain_active  <= 1'b0;
      drain_idx     <= '0;
      drain_cnt     <= '0;
      rec_valid     <= 1'b0;
    end else begin
      if (accept) begin
        // position holds on the end marker and after it, until a restart
        byte_position <= (ended_eff || end_mark) ? pos_eff : pos_eff + 5'd1;
        dir_ended     <= ended_eff || end_mark;
        if (entry_done && is_long) begin
          name_count <= lfn_count_next;
        end else if (drain_go) begin
          name_count <= '0;
        end else begin
          name_count <= cnt_eff;
        end
      end

      // read-out of stored characters, record last
      if (drain_go) begin
        drain_active <= 1'b1;
        drain_idx    <= '0;
        drain_cnt    <= cnt_eff;
      end else if (drain_active && out_free) begin
        if (drain_char) begin
          drain_idx <= drain_idx + CNT_W'(1);
        end else begin
          drain_active <= 1'b0;
        end
      end

      if (drain_active && out_free) begin
        rec_valid <= 1'b1;
      end else if (rec_valid && rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // entry bytes and name store write
  always_ff @(posedge clk) begin
    if (live) begin
      entry_bytes[pos_eff] <= dir_byte;
    end
    if (wr_en) begin
      name_store[wr_addr_full[IDX_W-1:0]] <= dir_byte;
    end
  end

  // output register; doubles as the name store's read data register
  always_ff @(posedge clk) begin
    if (drain_active && out_free) begin
      out_is_record <= !drain_char;
      if (drain_char) begin
        // character item: name field holds the character, all else zero
        out_rec <= {56'd0, name_store[drain_idx[IDX_W-1:0]], {REC_TAIL_W{1'b0}}};
      end else begin
        out_rec <= dec_rec;
      end
    end
  end

  assign is_record     = out_is_record;
  assign name_or_char  = out_rec.name;
  assign extension     = out_rec.extension;
  assign attribute     = out_rec.attribute;
  assign year          = out_rec.year;
  assign month         = out_rec.month;
  assign day           = out_rec.day;
  assign hour          = out_rec.hour;
  assign minute        = out_rec.minute;
  assign second_field  = out_rec.second_field;
  assign file_size     = out_rec.file_size;
  assign first_cluster = out_rec.first_cluster;

  // checks
  `FDEP_ASSERT_NOW(a_fill_bound, 1'b1, {1'b0, name_count} <= CHARS_MAX,
    "name store fill beyond its size")
  `FDEP_ASSERT_NOW(a_drain_bound, drain_active, drain_idx <= drain_cnt,
    "read-out index ran past the character count")
  `FDEP_ASSERT_NOW(a_char_in_drain, rec_valid && !is_record, drain_active,
    "character item shown outside a read-out")
  `FDEP_ASSERT_NOW(a_drain_ends_rec, $fell(drain_active) && !$past(rst),
    rec_valid && is_record, "read-out ended without a record item")

endmodule
